@@ sv/edc_pkg.sv @@
// shared types, constants and rounding and clamping helpers for the elastic disc collision block
// no dependencies
`timescale 1ns / 1ps

package edc_pkg;

   // register indexes on the csr port
   localparam logic CSR_MASS_FIRST  = 1'b0;
   localparam logic CSR_MASS_SECOND = 1'b1;

   // mass registers reset to 0.7 in Q8.8
   localparam logic [15:0] MASS_RESET = 16'd179;
   // mass ratio 2*m/M for equal masses, Q.16
   localparam logic [17:0] RATIO_RESET = 18'd65536;

   // register stages through the divide and square root unit
   localparam int DIV_STAGES  = 33;
   localparam int SQRT_STAGES = 17;
   localparam int UNIT_LAT    = DIV_STAGES + SQRT_STAGES;

   typedef struct packed {
      logic signed [31:0] first_pos_x;
      logic signed [31:0] first_pos_y;
      logic signed [31:0] first_vel_x;
      logic signed [31:0] first_vel_y;
      logic [30:0]        first_radius;
      logic signed [31:0] second_pos_x;
      logic signed [31:0] second_pos_y;
      logic signed [31:0] second_vel_x;
      logic signed [31:0] second_vel_y;
      logic [30:0]        second_radius;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_first_vel_x;
      logic signed [31:0] new_first_vel_y;
      logic signed [31:0] new_second_vel_x;
      logic signed [31:0] new_second_vel_y;
      logic               contact;
   } rsp_type;

   // mass ratios from the serial divider
   typedef struct packed {
      logic [17:0] k1;
      logic [17:0] k2;
      logic        msum_zero;
   } ratio_type;

   // divide by 2^16, round to nearest, ties away from zero
   function automatic logic signed [63:0] round16(input logic signed [63:0] x);
      logic [63:0] m;
      m = x[63] ? 64'(-x) : 64'(x);
      m = (m + 64'd32768) >> 16;
      return x[63] ? -$signed(m) : $signed(m);
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

endpackage

@@ sv/edc_unit_vec.sv @@
// pipelined normal component: restoring divide a2*2^32/ee then integer square root
// depends on edc_pkg
`timescale 1ns / 1ps

module edc_unit_vec
   import edc_pkg::*;
(
   input  logic        clock,
   input  logic [29:0] num,
   input  logic [30:0] den,
   output logic [16:0] root
);

   logic [30:0] div_rem_ff [0:DIV_STAGES-1];
   logic [32:0] div_q_ff   [0:DIV_STAGES-1];
   logic [30:0] div_den_ff [0:DIV_STAGES-1];

   logic [33:0] sq_x_ff    [0:SQRT_STAGES-1];
   logic [19:0] sq_rem_ff  [0:SQRT_STAGES-1];
   logic [16:0] sq_root_ff [0:SQRT_STAGES-1];

   // integer quotient bit, set only when the numerator equals the divisor
   always_ff @(posedge clock) begin
      div_den_ff[0] <= den;
      if ({1'b0, num} >= den) begin
         div_rem_ff[0] <= 31'({1'b0, num} - den);
         div_q_ff[0]   <= 33'd1;
      end else begin
         div_rem_ff[0] <= {1'b0, num};
         div_q_ff[0]   <= 33'd0;
      end
   end

   // one fraction bit a stage
   genvar i;
   generate
      for (i = 1; i < DIV_STAGES; i++) begin : g_div
         logic [31:0] trial_in;
         assign trial_in = {div_rem_ff[i-1], 1'b0};
         always_ff @(posedge clock) begin
            div_den_ff[i] <= div_den_ff[i-1];
            if (trial_in >= {1'b0, div_den_ff[i-1]}) begin
               div_rem_ff[i] <= 31'(trial_in - {1'b0, div_den_ff[i-1]});
               div_q_ff[i]   <= {div_q_ff[i-1][31:0], 1'b1};
            end else begin
               div_rem_ff[i] <= trial_in[30:0];
               div_q_ff[i]   <= {div_q_ff[i-1][31:0], 1'b0};
            end
         end
      end
   endgenerate

   // square root, one root bit a stage from the top bit pair
   generate
      for (i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
         logic [33:0] x_in;
         logic [19:0] rem_in;
         logic [16:0] root_in;
         logic [21:0] work_in;
         logic [18:0] trial_in;
         if (i == 0) begin : g_first
            assign x_in    = {1'b0, div_q_ff[DIV_STAGES-1]};
            assign rem_in  = '0;
            assign root_in = '0;
         end else begin : g_next
            assign x_in    = sq_x_ff[i-1];
            assign rem_in  = sq_rem_ff[i-1];
            assign root_in = sq_root_ff[i-1];
         end
         assign work_in  = {rem_in, x_in[33:32]};
         assign trial_in = {root_in, 2'b01};
         always_ff @(posedge clock) begin
            sq_x_ff[i] <= {x_in[31:0], 2'b00};
            if (work_in >= 22'(trial_in)) begin
               sq_rem_ff[i]  <= 20'(work_in - 22'(trial_in));
               sq_root_ff[i] <= {root_in[15:0], 1'b1};
            end else begin
               sq_rem_ff[i]  <= work_in[19:0];
               sq_root_ff[i] <= {root_in[15:0], 1'b0};
            end
         end
      end
   endgenerate

   assign root = sq_root_ff[SQRT_STAGES-1];

endmodule

@@ sv/edc_mass_div.sv @@
// serial divider for the mass ratios 2*m2/M and 2*m1/M, rerun after each mass write
// depends on edc_pkg
`timescale 1ns / 1ps

module edc_mass_div
   import edc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        kick,
   input  logic [15:0] mass_first,
   input  logic [15:0] mass_second,
   output ratio_type   ratio
);

   localparam int NUM_BITS = 34;

   logic        run_ff;
   logic [5:0]  count_ff;
   logic [33:0] n1_ff, n2_ff;
   logic [16:0] r1_ff, r2_ff;
   logic [17:0] q1_ff, q2_ff;
   logic [16:0] d_ff;
   ratio_type   ratio_ff;

   logic [16:0] msum_in;
   logic [17:0] t1_in, t2_in;
   logic        b1_in, b2_in;
   logic [17:0] q1_in, q2_in;

   assign msum_in = 17'(mass_first) + 17'(mass_second);

   // one quotient bit a cycle on both lanes while running
   always_comb begin
      t1_in = {r1_ff, n1_ff[33]};
      t2_in = {r2_ff, n2_ff[33]};
      b1_in = t1_in >= {1'b0, d_ff};
      b2_in = t2_in >= {1'b0, d_ff};
      q1_in = {q1_ff[16:0], b1_in};
      q2_in = {q2_ff[16:0], b2_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         count_ff <= '0;
         ratio_ff <= '{k1: RATIO_RESET, k2: RATIO_RESET, msum_zero: 1'b0};
      end else if (kick) begin
         run_ff   <= 1'b1;
         count_ff <= '0;
      end else if (run_ff) begin
         count_ff <= count_ff + 6'd1;
         if (count_ff == 6'(NUM_BITS - 1)) begin
            run_ff   <= 1'b0;
            ratio_ff <= '{k1: q1_in, k2: q2_in, msum_zero: (d_ff == '0)};
         end
      end
   end

   // datapath loads on kick, shifts while running
   always_ff @(posedge clock) begin
      if (kick) begin
         d_ff  <= msum_in;
         n1_ff <= (34'(mass_second) << 17) + 34'(msum_in >> 1);
         n2_ff <= (34'(mass_first) << 17) + 34'(msum_in >> 1);
         r1_ff <= '0;
         r2_ff <= '0;
         q1_ff <= '0;
         q2_ff <= '0;
      end else if (run_ff) begin
         n1_ff <= {n1_ff[32:0], 1'b0};
         n2_ff <= {n2_ff[32:0], 1'b0};
         r1_ff <= b1_in ? 17'(t1_in - {1'b0, d_ff}) : t1_in[16:0];
         r2_ff <= b2_in ? 17'(t2_in - {1'b0, d_ff}) : t2_in[16:0];
         q1_ff <= q1_in;
         q2_ff <= q2_in;
      end
   end

   assign ratio = ratio_ff;

endmodule

@@ sv/elastic_disc_collision_top.sv @@
// elastic collision response for two discs, fully pipelined
// depends on edc_pkg, edc_unit_vec, edc_mass_div
// one pair per cycle; the depth of the pipeline is set by the bit-per-stage divide and
// square root pipeline of the unit normal (50 stages)
// a mass write reruns the serial ratio divider; busy is high only during reset
// reset clears valid bits and sets both masses to 0.7
`timescale 1ns / 1ps

module elastic_disc_collision_top
   import edc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   typedef struct packed {
      logic signed [31:0] v1x;
      logic signed [31:0] v1y;
      logic signed [31:0] v2x;
      logic signed [31:0] v2y;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic               sdx;
      logic               sdy;
      logic               touch;
   } side_type;

   // configuration
   logic [15:0] mass_first_ff, mass_second_ff;
   logic        kick_ff;
   ratio_type   ratio;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_first_ff  <= MASS_RESET;
         mass_second_ff <= MASS_RESET;
         kick_ff        <= 1'b0;
      end else begin
         kick_ff <= csr_write;
         if (csr_write) begin
            case (csr_index)
               CSR_MASS_FIRST:  mass_first_ff  <= csr_data;
               CSR_MASS_SECOND: mass_second_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   edc_mass_div u_mass_div (
      .clock       (clock),
      .reset       (reset),
      .kick        (kick_ff),
      .mass_first  (mass_first_ff),
      .mass_second (mass_second_ff),
      .ratio       (ratio)
   );

   assign busy = reset;

   // input beat capture
   logic    in_vld_ff;
   req_type in_ff;

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else in_vld_ff <= start && !busy;
      in_ff <= req_payload;
   end

   // stage 1: differences and radius sum
   logic               st1_vld_ff;
   side_type           st1_side_ff;
   logic [31:0]        st1_ux_ff, st1_uy_ff, st1_rs_ff;
   logic signed [32:0] dx_in, dy_in;

   always_comb begin
      dx_in = 33'(in_ff.first_pos_x) - 33'(in_ff.second_pos_x);
      dy_in = 33'(in_ff.first_pos_y) - 33'(in_ff.second_pos_y);
   end

   always_ff @(posedge clock) begin
      if (reset) st1_vld_ff <= 1'b0;
      else st1_vld_ff <= in_vld_ff;
      st1_side_ff.v1x   <= in_ff.first_vel_x;
      st1_side_ff.v1y   <= in_ff.first_vel_y;
      st1_side_ff.v2x   <= in_ff.second_vel_x;
      st1_side_ff.v2y   <= in_ff.second_vel_y;
      st1_side_ff.dvx   <= 33'(in_ff.first_vel_x) - 33'(in_ff.second_vel_x);
      st1_side_ff.dvy   <= 33'(in_ff.first_vel_y) - 33'(in_ff.second_vel_y);
      st1_side_ff.sdx   <= dx_in[32];
      st1_side_ff.sdy   <= dy_in[32];
      st1_side_ff.touch <= 1'b0;
      st1_ux_ff <= dx_in[32] ? 32'(-dx_in) : dx_in[31:0];
      st1_uy_ff <= dy_in[32] ? 32'(-dy_in) : dy_in[31:0];
      st1_rs_ff <= 32'(in_ff.first_radius) + 32'(in_ff.second_radius);
   end

   // stage 2: squares
   logic        st2_vld_ff;
   side_type    st2_side_ff;
   logic [31:0] st2_ux_ff, st2_uy_ff;
   logic [63:0] st2_sqx_ff, st2_sqy_ff, st2_rr_ff;

   always_ff @(posedge clock) begin
      if (reset) st2_vld_ff <= 1'b0;
      else st2_vld_ff <= st1_vld_ff;
      st2_side_ff <= st1_side_ff;
      st2_ux_ff   <= st1_ux_ff;
      st2_uy_ff   <= st1_uy_ff;
      st2_sqx_ff  <= 64'(st1_ux_ff) * 64'(st1_ux_ff);
      st2_sqy_ff  <= 64'(st1_uy_ff) * 64'(st1_uy_ff);
      st2_rr_ff   <= 64'(st1_rs_ff) * 64'(st1_rs_ff);
   end

   // stage 3: contact test and leading one of |dx| | |dy|
   logic        st3_vld_ff;
   side_type    st3_side_ff;
   logic [31:0] st3_ux_ff, st3_uy_ff;
   logic [4:0]  st3_msb_ff;
   logic [64:0] dist_in;
   logic [31:0] or_in;
   logic [4:0]  msb_in;
   side_type    st3_side_in;

   always_comb begin
      dist_in = 65'(st2_sqx_ff) + 65'(st2_sqy_ff);
      or_in   = st2_ux_ff | st2_uy_ff;
      msb_in  = '0;
      for (int b = 0; b < 32; b++) begin
         if (or_in[b]) msb_in = 5'(b);
      end
      st3_side_in       = st2_side_ff;
      st3_side_in.touch = !dist_in[64] && (dist_in[63:0] <= st2_rr_ff) && (or_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) st3_vld_ff <= 1'b0;
      else st3_vld_ff <= st2_vld_ff;
      st3_side_ff <= st3_side_in;
      st3_ux_ff  <= st2_ux_ff;
      st3_uy_ff  <= st2_uy_ff;
      st3_msb_ff <= msb_in;
   end

   // stage 4: scale so the larger lies in [2^14, 2^15)
   logic        st4_vld_ff;
   side_type    st4_side_ff;
   logic [14:0] st4_a_ff, st4_b_ff;

   always_ff @(posedge clock) begin
      if (reset) st4_vld_ff <= 1'b0;
      else st4_vld_ff <= st3_vld_ff;
      st4_side_ff <= st3_side_ff;
      if (st3_msb_ff >= 5'd14) begin
         st4_a_ff <= 15'(st3_ux_ff >> (st3_msb_ff - 5'd14));
         st4_b_ff <= 15'(st3_uy_ff >> (st3_msb_ff - 5'd14));
      end else begin
         st4_a_ff <= 15'(st3_ux_ff << (5'd14 - st3_msb_ff));
         st4_b_ff <= 15'(st3_uy_ff << (5'd14 - st3_msb_ff));
      end
   end

   // stage 5: squared scaled components and their sum
   logic        st5_vld_ff;
   side_type    st5_side_ff;
   logic [29:0] st5_a2_ff, st5_b2_ff;
   logic [30:0] st5_ee_ff;
   logic [29:0] a2_in, b2_in;

   always_comb begin
      a2_in = 30'(st4_a_ff) * 30'(st4_a_ff);
      b2_in = 30'(st4_b_ff) * 30'(st4_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) st5_vld_ff <= 1'b0;
      else st5_vld_ff <= st4_vld_ff;
      st5_side_ff <= st4_side_ff;
      st5_a2_ff   <= a2_in;
      st5_b2_ff   <= b2_in;
      st5_ee_ff   <= 31'(a2_in) + 31'(b2_in);
   end

   // unit normal magnitudes
   logic [16:0] nx_mag, ny_mag;

   edc_unit_vec u_unit_x (
      .clock (clock),
      .num   (st5_a2_ff),
      .den   (st5_ee_ff),
      .root  (nx_mag)
   );

   edc_unit_vec u_unit_y (
      .clock (clock),
      .num   (st5_b2_ff),
      .den   (st5_ee_ff),
      .root  (ny_mag)
   );

   // side data delay matched to the unit
   logic [UNIT_LAT-1:0] dly_vld_ff;
   side_type            dly_side_ff [0:UNIT_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) dly_vld_ff <= '0;
      else dly_vld_ff <= {dly_vld_ff[UNIT_LAT-2:0], st5_vld_ff};
      dly_side_ff[0] <= st5_side_ff;
      for (int s = 1; s < UNIT_LAT; s++) begin
         dly_side_ff[s] <= dly_side_ff[s-1];
      end
   end

   side_type dly_side;
   assign dly_side = dly_side_ff[UNIT_LAT-1];

   // stage 7: signed normal and its products with the relative velocity
   logic               st7_vld_ff;
   side_type           st7_side_ff;
   logic signed [17:0] st7_nx_ff, st7_ny_ff;
   logic signed [50:0] st7_px_ff, st7_py_ff;
   logic signed [17:0] nx_in, ny_in;

   always_comb begin
      nx_in = dly_side.sdx ? -$signed({1'b0, nx_mag}) : $signed({1'b0, nx_mag});
      ny_in = dly_side.sdy ? -$signed({1'b0, ny_mag}) : $signed({1'b0, ny_mag});
   end

   always_ff @(posedge clock) begin
      if (reset) st7_vld_ff <= 1'b0;
      else st7_vld_ff <= dly_vld_ff[UNIT_LAT-1];
      st7_side_ff <= dly_side;
      st7_nx_ff   <= nx_in;
      st7_ny_ff   <= ny_in;
      st7_px_ff   <= nx_in * dly_side.dvx;
      st7_py_ff   <= ny_in * dly_side.dvy;
   end

   // stage 8: normal relative speed g
   logic               st8_vld_ff;
   side_type           st8_side_ff;
   logic signed [17:0] st8_nx_ff, st8_ny_ff;
   logic signed [35:0] st8_g_ff;
   logic signed [51:0] dot_in;

   assign dot_in = 52'(st7_px_ff) + 52'(st7_py_ff);

   always_ff @(posedge clock) begin
      if (reset) st8_vld_ff <= 1'b0;
      else st8_vld_ff <= st7_vld_ff;
      st8_side_ff <= st7_side_ff;
      st8_nx_ff   <= st7_nx_ff;
      st8_ny_ff   <= st7_ny_ff;
      st8_g_ff    <= 36'(round16(64'(dot_in)));
   end

   // stage 9: scale by the mass ratios
   logic               st9_vld_ff;
   side_type           st9_side_ff;
   logic signed [17:0] st9_nx_ff, st9_ny_ff;
   logic signed [54:0] st9_gk1_ff, st9_gk2_ff;
   logic               st9_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) st9_vld_ff <= 1'b0;
      else st9_vld_ff <= st8_vld_ff;
      st9_side_ff <= st8_side_ff;
      st9_nx_ff   <= st8_nx_ff;
      st9_ny_ff   <= st8_ny_ff;
      st9_gk1_ff  <= st8_g_ff * $signed({1'b0, ratio.k1});
      st9_gk2_ff  <= st8_g_ff * $signed({1'b0, ratio.k2});
      st9_zero_ff <= ratio.msum_zero;
   end

   // stage 10: rounded impulse terms
   logic               st10_vld_ff;
   side_type           st10_side_ff;
   logic signed [17:0] st10_nx_ff, st10_ny_ff;
   logic signed [38:0] st10_t1_ff, st10_t2_ff;
   logic               st10_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) st10_vld_ff <= 1'b0;
      else st10_vld_ff <= st9_vld_ff;
      st10_side_ff <= st9_side_ff;
      st10_nx_ff   <= st9_nx_ff;
      st10_ny_ff   <= st9_ny_ff;
      st10_t1_ff   <= 39'(round16(64'(st9_gk1_ff)));
      st10_t2_ff   <= 39'(round16(64'(st9_gk2_ff)));
      st10_zero_ff <= st9_zero_ff;
   end

   // stage 11: velocity change products
   logic               st11_vld_ff;
   side_type           st11_side_ff;
   logic signed [56:0] st11_d1x_ff, st11_d1y_ff, st11_d2x_ff, st11_d2y_ff;
   logic               st11_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) st11_vld_ff <= 1'b0;
      else st11_vld_ff <= st10_vld_ff;
      st11_side_ff <= st10_side_ff;
      st11_d1x_ff  <= st10_nx_ff * st10_t1_ff;
      st11_d1y_ff  <= st10_ny_ff * st10_t1_ff;
      st11_d2x_ff  <= st10_nx_ff * st10_t2_ff;
      st11_d2y_ff  <= st10_ny_ff * st10_t2_ff;
      st11_zero_ff <= st10_zero_ff;
   end

   // output stage: apply, saturate, or pass through
   logic    out_vld_ff;
   rsp_type out_ff;
   logic    apply_in;

   assign apply_in = st11_side_ff.touch && !st11_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= st11_vld_ff;
      out_ff.contact <= st11_side_ff.touch;
      if (apply_in) begin
         out_ff.new_first_vel_x  <= sat32(64'(st11_side_ff.v1x) - round16(64'(st11_d1x_ff)));
         out_ff.new_first_vel_y  <= sat32(64'(st11_side_ff.v1y) - round16(64'(st11_d1y_ff)));
         out_ff.new_second_vel_x <= sat32(64'(st11_side_ff.v2x) + round16(64'(st11_d2x_ff)));
         out_ff.new_second_vel_y <= sat32(64'(st11_side_ff.v2y) + round16(64'(st11_d2y_ff)));
      end else begin
         out_ff.new_first_vel_x  <= st11_side_ff.v1x;
         out_ff.new_first_vel_y  <= st11_side_ff.v1y;
         out_ff.new_second_vel_x <= st11_side_ff.v2x;
         out_ff.new_second_vel_y <= st11_side_ff.v2y;
      end
   end

   assign rsp_strobe  = out_vld_ff;
   assign rsp_payload = out_ff;

endmodule
